/* design/anxb_pkg.sv */
// Shared types and constants for the Annex B NAL splitter.
// Holds the result record passed from the scanner to the top level.
// No dependencies.
package anxb_pkg;

    // Default sizing for the top-level parameters
    localparam int DEFAULT_MAX_UNITS     = 32;
    localparam int DEFAULT_POSITION_BITS = 24;

    // Fixed widths of the result fields
    localparam int OUT_POS_W = 24;
    localparam int TYPE_W    = 6;
    localparam int TOTAL_W   = 6;

    // Stream byte codes
    localparam logic [7:0] ZERO_BYTE   = 8'h00;
    localparam logic [7:0] SC_END_BYTE = 8'h01;

    // NAL type mask applied to bits 6..1 of the header byte
    localparam logic [TYPE_W-1:0] TYPE_MASK = 6'h3F;

    // One result beat
    typedef struct packed {
        logic                 nal_valid;
        logic [OUT_POS_W-1:0] nal_offset;
        logic [OUT_POS_W-1:0] nal_length;
        logic [TYPE_W-1:0]    nal_type;
        logic                 stream_end;
        logic [TOTAL_W-1:0]   nal_total;
    } nal_res_t;

endpackage

/* design/anxb_scan.sv */
// Start-code scanner: next-state and result logic for one stream byte.
// Purely combinational; the top level holds the state registers.
// Depends on anxb_pkg.
module anxb_scan #(
    parameter int MAX_UNITS     = anxb_pkg::DEFAULT_MAX_UNITS,
    parameter int POSITION_BITS = anxb_pkg::DEFAULT_POSITION_BITS,
    parameter int UNIT_W        = $clog2(MAX_UNITS + 1)
) (
    input  logic [7:0]                     data_byte,
    input  logic                           last_byte,
    input  logic [POSITION_BITS-1:0]       pos,
    input  logic [23:0]                    recent,
    input  logic                           in_nal,
    input  logic [POSITION_BITS-1:0]       cur_start,
    input  logic [anxb_pkg::TYPE_W-1:0]    cur_type,
    input  logic [UNIT_W-1:0]              units,
    output logic [POSITION_BITS-1:0]       pos_next,
    output logic [23:0]                    recent_next,
    output logic                           inside_next,
    output logic [POSITION_BITS-1:0]       start_next,
    output logic [anxb_pkg::TYPE_W-1:0]    type_next,
    output logic [UNIT_W-1:0]              units_next,
    output logic                           res_valid,
    output anxb_pkg::nal_res_t             res
);

    localparam logic [UNIT_W-1:0] MAX_CNT = UNIT_W'(MAX_UNITS);

    logic                                      sc;
    logic                                      ins;
    logic [POSITION_BITS-1:0]                  start;
    logic [anxb_pkg::TYPE_W-1:0]               typ;
    logic [UNIT_W-1:0]                         cnt;
    logic                                      emit;
    logic [POSITION_BITS-1:0]                  e_off;
    logic [POSITION_BITS-1:0]                  e_len;
    logic [anxb_pkg::TYPE_W-1:0]               e_typ;
    logic [POSITION_BITS-1:0]                  end_pos;
    logic [POSITION_BITS-1:0]                  len;
    logic [POSITION_BITS+anxb_pkg::OUT_POS_W-1:0] off_ext;
    logic [POSITION_BITS+anxb_pkg::OUT_POS_W-1:0] len_ext;
    logic [UNIT_W+anxb_pkg::TOTAL_W-1:0]       cnt_ext;

    // 00 00 01 ending at this byte
    assign sc = (data_byte == anxb_pkg::SC_END_BYTE)
             && (recent[7:0] == anxb_pkg::ZERO_BYTE)
             && (recent[15:8] == anxb_pkg::ZERO_BYTE);

    // NAL open/close decisions
    always_comb begin
        ins     = in_nal;
        start   = cur_start;
        typ     = cur_type;
        cnt     = units;
        emit    = 1'b0;
        e_off   = '0;
        e_len   = '0;
        e_typ   = '0;
        end_pos = '0;
        len     = '0;

        if (units < MAX_CNT) begin
            if (ins) begin
                // first payload byte carries the type
                if (pos == start) begin
                    typ = data_byte[6:1] & anxb_pkg::TYPE_MASK;
                end
                if (sc) begin
                    // a zero before 00 00 01 belongs to the 4-byte code
                    if (recent[23:16] == anxb_pkg::ZERO_BYTE) begin
                        end_pos = pos - POSITION_BITS'(3);
                    end else begin
                        end_pos = pos - POSITION_BITS'(2);
                    end
                    len = end_pos - start;
                    if (len != '0) begin
                        emit  = 1'b1;
                        e_off = start;
                        e_len = len;
                        e_typ = typ;
                        cnt   = cnt + UNIT_W'(1);
                    end
                    ins = 1'b0;
                end
            end
            if (sc && !last_byte && (cnt < MAX_CNT)) begin
                ins   = 1'b1;
                start = pos + POSITION_BITS'(1);
                typ   = '0;
            end
        end else begin
            ins = 1'b0;
        end

        // stream end closes an open NAL
        if (last_byte && !emit && ins) begin
            len = pos + POSITION_BITS'(1) - start;
            if (len != '0) begin
                emit  = 1'b1;
                e_off = start;
                e_len = len;
                e_typ = typ;
                cnt   = cnt + UNIT_W'(1);
            end
        end
    end

    // Next state; a stream end returns everything to reset values
    always_comb begin
        if (last_byte) begin
            pos_next    = '0;
            recent_next = '1;
            inside_next = 1'b0;
            start_next  = '0;
            type_next   = '0;
            units_next  = '0;
        end else begin
            pos_next    = pos + POSITION_BITS'(1);
            recent_next = {recent[15:0], data_byte};
            inside_next = ins;
            start_next  = start;
            type_next   = typ;
            units_next  = cnt;
        end
    end

    // Result record, fields zero-extended or truncated to output widths
    assign off_ext = {{anxb_pkg::OUT_POS_W{1'b0}}, e_off};
    assign len_ext = {{anxb_pkg::OUT_POS_W{1'b0}}, e_len};
    assign cnt_ext = {{anxb_pkg::TOTAL_W{1'b0}}, cnt};

    assign res_valid      = emit || last_byte;
    assign res.nal_valid  = emit;
    assign res.nal_offset = off_ext[anxb_pkg::OUT_POS_W-1:0];
    assign res.nal_length = len_ext[anxb_pkg::OUT_POS_W-1:0];
    assign res.nal_type   = e_typ;
    assign res.stream_end = last_byte;
    assign res.nal_total  = cnt_ext[anxb_pkg::TOTAL_W-1:0];

endmodule

/* design/annexb_nal_splitter_core.sv */
// Top level of the HEVC Annex B NAL splitter: stream ports, state and
// result registers around the start-code scanner.
// Depends on anxb_pkg and anxb_scan.
//
// Takes one stream byte per beat (tlast marks the final byte) and emits a
// beat per completed NAL unit giving offset, length and type; the final
// byte's beat carries the stream-end mark and the unit count, plus any unit it
// completes. Bytes are scanned against a three-byte history, so one byte is
// accepted every clock unless stalled; a result appears in the cycle after
// the byte that completes it. The input is stalled only while a result sits
// in the output register and the downstream side is not taking it. Positions
// wrap modulo 2^POSITION_BITS; after MAX_UNITS units, bytes are only counted.
module annexb_nal_splitter_core #(
    parameter int MAX_UNITS     = anxb_pkg::DEFAULT_MAX_UNITS,
    parameter int POSITION_BITS = anxb_pkg::DEFAULT_POSITION_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    // NAL results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [23:0] nal_offset, [47:24] nal_length,
                                   // [53:48] nal_type, [59:54] nal_total, zero pad
    output logic        m_tuser,   // nal_valid
    output logic        m_tlast    // stream_end
);

    localparam int UNIT_W = $clog2(MAX_UNITS + 1);

    logic [POSITION_BITS-1:0]    pos_reg,    pos_next;
    logic [23:0]                 recent_reg, recent_next;
    logic                        inside_reg, inside_next;
    logic [POSITION_BITS-1:0]    start_reg,  start_next;
    logic [anxb_pkg::TYPE_W-1:0] type_reg,   type_next;
    logic [UNIT_W-1:0]           units_reg,  units_next;
    logic                        res_valid;
    anxb_pkg::nal_res_t          res;
    anxb_pkg::nal_res_t          out_reg;
    logic                        out_valid_reg;
    logic                        accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    anxb_scan #(
        .MAX_UNITS     (MAX_UNITS),
        .POSITION_BITS (POSITION_BITS),
        .UNIT_W        (UNIT_W)
    ) u_scan (
        .data_byte   (s_tdata),
        .last_byte   (s_tlast),
        .pos         (pos_reg),
        .recent      (recent_reg),
        .in_nal      (inside_reg),
        .cur_start   (start_reg),
        .cur_type    (type_reg),
        .units       (units_reg),
        .pos_next    (pos_next),
        .recent_next (recent_next),
        .inside_next (inside_next),
        .start_next  (start_next),
        .type_next   (type_next),
        .units_next  (units_next),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Scanner state, advanced on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            recent_reg <= '1;
            inside_reg <= 1'b0;
            start_reg  <= '0;
            type_reg   <= '0;
            units_reg  <= '0;
        end else if (accept) begin
            pos_reg    <= pos_next;
            recent_reg <= recent_next;
            inside_reg <= inside_next;
            start_reg  <= start_next;
            type_reg   <= type_next;
            units_reg  <= units_next;
        end
    end

    // Output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.nal_total, out_reg.nal_type,
                       out_reg.nal_length, out_reg.nal_offset};
    assign m_tuser  = out_reg.nal_valid;
    assign m_tlast  = out_reg.stream_end;

endmodule
